FILE: hdl/ecnq_pkg.sv
`default_nettype none

package ecnq_pkg;

  // Field widths of the item channels.
  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int SIZE_W   = 14;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 24;
  localparam int DROPS_W  = 32;
  localparam int SEND_W   = 2;
  localparam int CFG_W    = 24;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Input operation codes.
  localparam logic [OP_W-1:0] OP_ARRIVE   = 2'd0;
  localparam logic [OP_W-1:0] OP_PAUSE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESUME   = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEPARTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CONTROL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // Sender states.
  localparam logic [SEND_W-1:0] SS_READY    = 2'd0;
  localparam logic [SEND_W-1:0] SS_PAUSE_RX = 2'd1;
  localparam logic [SEND_W-1:0] SS_PAUSED   = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic REG_MARK_THR  = 1'b1;
  localparam logic [CFG_W-1:0] MAX_BYTES_RST = 24'd65536;
  localparam logic [CFG_W-1:0] MARK_THR_RST  = 24'd16384;

  typedef struct packed {
    logic [CFG_W-1:0] max_bytes;
    logic [CFG_W-1:0] mark_threshold;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic              ce;
  } desc_t;

endpackage

`default_nettype wire

FILE: hdl/ecn_marking_pausable_fifo.sv
`default_nettype none

// Packet descriptor queue with a byte limit, link pause and ECN marking. Each
// item (arrival, pause, resume or transmit completion) yields exactly one
// result item. In the accept cycle the descriptor memory is read at the head
// slot; the item then executes: the queue state is updated and an arrival is
// written at the tail slot. The execute step waits while an earlier result is
// still held stalled in the output register. The descriptor memory needs no
// clearing after reset, so items are taken from the first cycle after reset.
// Configuration is written over the APB port; the user must write it only
// while no item is in progress, as the block itself does not enforce this.
module ecn_marking_pausable_fifo #(
  parameter int DEPTH     = 64,
  parameter int BYTE_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input item channel.
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ecnq_pkg::OP_W-1:0]       op_i,
  input  wire logic [ecnq_pkg::ID_W-1:0]       pkt_id_i,
  input  wire logic [ecnq_pkg::SIZE_W-1:0]     pkt_size_i,
  input  wire logic                            ce_in_i,
  // Result item channel.
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [ecnq_pkg::STATUS_W-1:0]   status_o,
  output logic                                 start_service_o,
  output logic      [ecnq_pkg::ID_W-1:0]       out_id_o,
  output logic      [ecnq_pkg::SIZE_W-1:0]     out_size_o,
  output logic                                 ce_out_o,
  output logic      [ecnq_pkg::OCC_W-1:0]      occupancy_o,
  output logic      [ecnq_pkg::DROPS_W-1:0]    drops_o,
  output logic      [ecnq_pkg::SEND_W-1:0]     send_state_o,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ecnq_pkg::APB_AW-1:0]     paddr,
  input  wire logic [ecnq_pkg::APB_DW-1:0]     pwdata,
  output logic      [ecnq_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CAPW  = (BYTE_BITS > ecnq_pkg::CFG_W) ? BYTE_BITS : ecnq_pkg::CFG_W;
  localparam int SW    = CAPW + 1;
  localparam int OccW  = ecnq_pkg::OCC_W;
  localparam int DescW = $bits(ecnq_pkg::desc_t);
  localparam logic [SW-1:0] ByteMask = SW'((64'd1 << BYTE_BITS) - 64'd1);
  localparam logic [PW-1:0] LastPtr  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  ecnq_pkg::cfg_t  cfg;
  ecnq_pkg::desc_t rd_desc;
  ecnq_pkg::desc_t wr_desc;
  logic [DescW-1:0] rd_word;

  logic                          state_q, state_d;
  logic [ecnq_pkg::OP_W-1:0]     op_q;
  logic [ecnq_pkg::ID_W-1:0]     id_q;
  logic [ecnq_pkg::SIZE_W-1:0]   size_q;
  logic                          ce_q;

  logic [PW-1:0]                 head_q, head_d;
  logic [PW-1:0]                 tail_q, tail_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [BYTE_BITS-1:0]          occ_q, occ_d;
  logic [ecnq_pkg::SEND_W-1:0]   sstate_q, sstate_d;
  logic [ecnq_pkg::DROPS_W-1:0]  drops_q, drops_d;

  logic                          out_valid_q;
  logic [ecnq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          start_q, start_d;
  logic [ecnq_pkg::ID_W-1:0]     oid_q, oid_d;
  logic [ecnq_pkg::SIZE_W-1:0]   osize_q, osize_d;
  logic                          oce_q, oce_d;

  logic          in_accept;
  logic          out_free;
  logic          exec_fire;
  logic          wr_en;
  logic [SW-1:0] cap;
  logic [SW-1:0] max_ext;
  logic [SW-1:0] occ_ext;
  logic [SW-1:0] size_ext;
  logic [SW-1:0] sum;

  ecnq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign wr_desc.id   = id_q;
  assign wr_desc.size = size_q;
  assign wr_desc.ce   = ce_q;
  assign rd_desc      = ecnq_pkg::desc_t'(rd_word);

  ecnq_desc_ram #(
    .DEPTH (DEPTH),
    .PW    (PW),
    .W     (DescW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (wr_desc),
    .re_i    (in_accept),
    .raddr_i (head_q),
    .rdata_o (rd_word)
  );

  // Handshakes: one item in flight, the execute cycle waits on a held result.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !(out_valid_q && out_stall_i);
  assign exec_fire  = (state_q == S_EXEC) && out_free;

  // Byte arithmetic, wide enough to hold the limit and a sum without wrap.
  assign max_ext  = SW'(cfg.max_bytes);
  assign cap      = (max_ext > ByteMask) ? ByteMask : max_ext;
  assign occ_ext  = SW'(occ_q);
  assign size_ext = SW'(size_q);
  assign sum      = occ_ext + size_ext;

  // Execute step of the queue.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    occ_d    = occ_q;
    sstate_d = sstate_q;
    drops_d  = drops_q;
    status_d = ecnq_pkg::ST_CONTROL;
    start_d  = 1'b0;
    oid_d    = id_q;
    osize_d  = '0;
    oce_d    = 1'b0;
    wr_en    = 1'b0;
    unique case (op_q)
      ecnq_pkg::OP_ARRIVE: begin
        if ((sum > cap) || (count_q >= FullCnt)) begin
          status_d = ecnq_pkg::ST_DROPPED;
          drops_d  = drops_q + 1'b1;
        end else begin
          wr_en    = exec_fire;
          tail_d   = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
          count_d  = count_q + 1'b1;
          occ_d    = BYTE_BITS'(sum);
          status_d = ecnq_pkg::ST_ACCEPTED;
          start_d  = (count_q == '0) && (sstate_q == ecnq_pkg::SS_READY);
        end
      end
      ecnq_pkg::OP_PAUSE: begin
        sstate_d = (count_q != '0) ? ecnq_pkg::SS_PAUSE_RX : ecnq_pkg::SS_PAUSED;
      end
      ecnq_pkg::OP_RESUME: begin
        sstate_d = ecnq_pkg::SS_READY;
        start_d  = (count_q != '0);
      end
      ecnq_pkg::OP_COMPLETE: begin
        if (count_q == '0) begin
          status_d = ecnq_pkg::ST_EMPTY;
        end else begin
          head_d  = (head_q == LastPtr) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
          if (sstate_q == ecnq_pkg::SS_PAUSE_RX) begin
            sstate_d = ecnq_pkg::SS_PAUSED;
          end
          oid_d    = rd_desc.id;
          osize_d  = rd_desc.size;
          oce_d    = rd_desc.ce | (occ_ext > SW'(cfg.mark_threshold));
          occ_d    = (occ_ext >= SW'(rd_desc.size)) ?
                     BYTE_BITS'(occ_ext - SW'(rd_desc.size)) : '0;
          status_d = ecnq_pkg::ST_DEPARTED;
          start_d  = (count_d != '0) && (sstate_d == ecnq_pkg::SS_READY);
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_accept) state_d = S_EXEC;
      S_EXEC:  if (out_free)  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and queue registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      occ_q       <= '0;
      sstate_q    <= ecnq_pkg::SS_READY;
      drops_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        occ_q       <= occ_d;
        sstate_q    <= sstate_d;
        drops_q     <= drops_d;
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Accepted item and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_i;
      id_q   <= pkt_id_i;
      size_q <= pkt_size_i;
      ce_q   <= ce_in_i;
    end
    if (exec_fire) begin
      status_q <= status_d;
      start_q  <= start_d;
      oid_q    <= oid_d;
      osize_q  <= osize_d;
      oce_q    <= oce_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign start_service_o = start_q;
  assign out_id_o        = oid_q;
  assign out_size_o      = osize_q;
  assign ce_out_o        = oce_q;
  assign occupancy_o     = OccW'(SW'(occ_q));
  assign drops_o         = drops_q;
  assign send_state_o    = sstate_q;

endmodule

`default_nettype wire

FILE: hdl/ecnq_desc_ram.sv
`default_nettype none

module ecnq_desc_ram #(
  parameter int DEPTH = 64,
  parameter int PW    = 6,
  parameter int W     = 31
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [PW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [PW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/ecnq_cfg.sv
`default_nettype none

module ecnq_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ecnq_pkg::APB_AW-1:0]   paddr,
  input  wire logic [ecnq_pkg::APB_DW-1:0]   pwdata,
  output logic      [ecnq_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output ecnq_pkg::cfg_t                     cfg_o
);

  logic [ecnq_pkg::CFG_W-1:0] max_bytes_q;
  logic [ecnq_pkg::CFG_W-1:0] mark_thr_q;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= ecnq_pkg::MAX_BYTES_RST;
      mark_thr_q  <= ecnq_pkg::MARK_THR_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        ecnq_pkg::REG_MAX_BYTES: max_bytes_q <= pwdata[ecnq_pkg::CFG_W-1:0];
        ecnq_pkg::REG_MARK_THR:  mark_thr_q  <= pwdata[ecnq_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_sel)
      ecnq_pkg::REG_MAX_BYTES: prdata = ecnq_pkg::APB_DW'(max_bytes_q);
      ecnq_pkg::REG_MARK_THR:  prdata = ecnq_pkg::APB_DW'(mark_thr_q);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.max_bytes      = max_bytes_q;
  assign cfg_o.mark_threshold = mark_thr_q;

endmodule

`default_nettype wire

FILE: hdl/ecnq_checker.sv
`default_nettype none

module ecnq_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [ecnq_pkg::STATUS_W-1:0]   status_o,
  input wire logic                            start_service_o,
  input wire logic [ecnq_pkg::SIZE_W-1:0]     out_size_o,
  input wire logic                            ce_out_o,
  input wire logic [ecnq_pkg::SEND_W-1:0]     send_state_o
);

  // A result held under stall stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // One item at a time: the cycle after an accept takes no new item.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted during execution");

  // Only departures carry a length or a congestion mark.
  a_clean_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ecnq_pkg::ST_DEPARTED) |-> (out_size_o == '0) && !ce_out_o)
    else $error("non-departure result carries packet fields");

  // Service starts only while the sender is ready.
  a_start_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_service_o |-> send_state_o == ecnq_pkg::SS_READY)
    else $error("service start while sender paused");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ecnq_pkg::ST_EMPTY)
    else $error("undefined status code");

endmodule

bind ecn_marking_pausable_fifo ecnq_checker u_ecnq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .start_service_o (start_service_o),
  .out_size_o      (out_size_o),
  .ce_out_o        (ce_out_o),
  .send_state_o    (send_state_o)
);

`default_nettype wire

FILE: test/tb_ecn_marking_pausable_fifo.sv
`default_nettype none

module tb_ecn_marking_pausable_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import ecnq_pkg::*;

  localparam int QDEPTH      = 64;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QBYTE_BITS  = 24;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 330;
  localparam int BURST_LEN   = 40;
  localparam int STUCK_LIMIT = 2000;

  // Packet size profiles for random items.
  localparam int SZ_SMALL = 0;
  localparam int SZ_FULL  = 1;
  localparam int SZ_MIXED = 2;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic              ce;
  } pkt_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                start;
    logic [ID_W-1:0]     id;
    logic [SIZE_W-1:0]   size;
    logic                ce;
    logic [OCC_W-1:0]    occ;
    logic [DROPS_W-1:0]  drops;
    logic [SEND_W-1:0]   state;
  } queue_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i;
  logic [ID_W-1:0]     pkt_id_i;
  logic [SIZE_W-1:0]   pkt_size_i;
  logic                ce_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic                start_service_o;
  logic [ID_W-1:0]     out_id_o;
  logic [SIZE_W-1:0]   out_size_o;
  logic                ce_out_o;
  logic [OCC_W-1:0]    occupancy_o;
  logic [DROPS_W-1:0]  drops_o;
  logic [SEND_W-1:0]   send_state_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  ecn_marking_pausable_fifo #(
    .DEPTH     (QDEPTH),
    .BYTE_BITS (QBYTE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .pkt_id_i        (pkt_id_i),
    .pkt_size_i      (pkt_size_i),
    .ce_in_i         (ce_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .start_service_o (start_service_o),
    .out_id_o        (out_id_o),
    .out_size_o      (out_size_o),
    .ce_out_o        (ce_out_o),
    .occupancy_o     (occupancy_o),
    .drops_o         (drops_o),
    .send_state_o    (send_state_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Items waiting to be sent and results the queue model expects back.
  pkt_item_t     pending_items[$];
  queue_result_t expected_results[$];

  // Shadow of the descriptor queue and its configuration.
  desc_t              slot_mem [QDEPTH];
  int unsigned        q_head;
  int unsigned        q_tail;
  int unsigned        q_count;
  logic [OCC_W-1:0]   q_bytes;
  logic [SEND_W-1:0]  snd_state;
  logic [DROPS_W-1:0] drop_total;
  logic [CFG_W-1:0]   cap_bytes;
  logic [CFG_W-1:0]   mark_thr;

  // Run statistics.
  int n_accepted, n_byte_drops, n_full_drops, n_departed, n_marked;
  int n_empty_done, n_controls, peak_depth;

  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned stuck_cycles;
  logic        in_acc;
  logic        moved;
  pkt_item_t     next_item;
  pkt_item_t     seen_item;
  queue_result_t want_r;

  // Settings per random phase.
  logic [CFG_W-1:0] phase_cap [NUM_PHASES] =
    '{24'd65536, 24'hFFFFFF, 24'd0, 24'd40000, 24'hFFFFFF, 24'd1000};
  logic [CFG_W-1:0] phase_thr [NUM_PHASES] =
    '{24'd16384, 24'd0, 24'hFFFFFF, 24'd20000, 24'hFFFFFF, 24'd500};
  int phase_sizes [NUM_PHASES] =
    '{SZ_MIXED, SZ_SMALL, SZ_MIXED, SZ_FULL, SZ_MIXED, SZ_SMALL};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one item to the shadow queue and record the result it must produce.
  // With 24-bit byte counters the capacity register never needs clamping.
  task automatic predict_result(input pkt_item_t it);
    queue_result_t r;
    desc_t         d;
    r.status = ST_CONTROL;
    r.start  = 1'b0;
    r.id     = it.id;
    r.size   = '0;
    r.ce     = 1'b0;
    case (it.op)
      OP_ARRIVE: begin
        if (({1'b0, q_bytes} + it.size) > {1'b0, cap_bytes} || q_count >= QDEPTH) begin
          r.status = ST_DROPPED;
          drop_total++;
          if (q_count >= QDEPTH) n_full_drops++;
          else n_byte_drops++;
        end else begin
          r.start = (q_count == 0) && (snd_state == SS_READY);
          d = {it.id, it.size, it.ce};
          slot_mem[q_tail[QPTR_W-1:0]] = d;
          q_tail = (q_tail + 1) % QDEPTH;
          q_count++;
          q_bytes = q_bytes + it.size;
          r.status = ST_ACCEPTED;
          n_accepted++;
          if (q_count > peak_depth) peak_depth = q_count;
        end
      end
      OP_PAUSE: begin
        // A queued zero-length packet still counts as in flight.
        snd_state = (q_count > 0) ? SS_PAUSE_RX : SS_PAUSED;
        n_controls++;
      end
      OP_RESUME: begin
        snd_state = SS_READY;
        r.start = (q_count > 0);
        n_controls++;
      end
      OP_COMPLETE: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
          n_empty_done++;
        end else begin
          d = slot_mem[q_head[QPTR_W-1:0]];
          q_head = (q_head + 1) % QDEPTH;
          q_count--;
          if (snd_state == SS_PAUSE_RX) snd_state = SS_PAUSED;
          r.id   = d.id;
          r.size = d.size;
          // Marking uses the occupancy before the packet is removed.
          r.ce   = d.ce | (q_bytes > mark_thr);
          if (q_bytes > mark_thr) n_marked++;
          q_bytes = (q_bytes >= d.size) ? q_bytes - d.size : '0;
          r.status = ST_DEPARTED;
          r.start = (q_count > 0) && (snd_state == SS_READY);
          n_departed++;
        end
      end
    endcase
    r.occ   = q_bytes;
    r.drops = drop_total;
    r.state = snd_state;
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [SIZE_W-1:0] size, input logic ce);
    pkt_item_t it;
    it.op   = op;
    it.id   = id;
    it.size = size;
    it.ce   = ce;
    pending_items.push_back(it);
  endtask

  function automatic pkt_item_t rand_item(input int arrive_pct, input int size_mode);
    pkt_item_t it;
    int        r;
    int        pick;
    r = $urandom_range(0, 99);
    if (r < arrive_pct) it.op = OP_ARRIVE;
    else if (r < arrive_pct + ((100 - arrive_pct) * 3) / 4) it.op = OP_COMPLETE;
    else if (r % 2 == 0) it.op = OP_PAUSE;
    else it.op = OP_RESUME;
    it.id = ID_W'($urandom_range(0, 65535));
    it.ce = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 3);
    if (size_mode == SZ_SMALL) it.size = SIZE_W'($urandom_range(0, 63));
    else if (size_mode == SZ_FULL || pick >= 2) it.size = SIZE_W'($urandom_range(0, 16383));
    else if (pick == 1) it.size = SIZE_W'($urandom_range(1, 63));
    else it.size = '0;
    return it;
  endfunction

  // Write a register over APB, then read it back.
  task automatic set_register(input logic idx, input logic [CFG_W-1:0] value);
    logic [APB_AW-1:0] addr;
    addr = APB_AW'(idx) << 2;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_MAX_BYTES) cap_bytes = value;
    else mark_thr = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    check_field("register readback", APB_DW'(value), APB_DW'(prdata[CFG_W-1:0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every item has gone in and every result has come out.
  task automatic drain_queue();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Item driver: holds a stalled item, else offers the next one or idles.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_acc)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        op_i       <= next_item.op;
        pkt_id_i   <= next_item.id;
        pkt_size_i <= next_item.size;
        ce_in_i    <= next_item.ce;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: checks results, predicts accepted items and watches for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = psel && penable;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, status %0d id 0x%0h",
                   $time, status_o, out_id_o);
          mismatch_count++;
        end else begin
          want_r = expected_results.pop_front();
          check_field("status", 32'(want_r.status), 32'(status_o));
          check_field("start_service", 32'(want_r.start), 32'(start_service_o));
          check_field("out_id", 32'(want_r.id), 32'(out_id_o));
          check_field("out_size", 32'(want_r.size), 32'(out_size_o));
          check_field("ce_out", 32'(want_r.ce), 32'(ce_out_o));
          check_field("occupancy", 32'(want_r.occ), 32'(occupancy_o));
          check_field("drops", want_r.drops, drops_o);
          check_field("send_state", 32'(want_r.state), 32'(send_state_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        seen_item.op   = op_i;
        seen_item.id   = pkt_id_i;
        seen_item.size = pkt_size_i;
        seen_item.ce   = ce_in_i;
        predict_result(seen_item);
      end
      in_acc <= in_valid_i && !in_stall_o;
      if (moved) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, stuck_cycles);
        $display("tb_ecn_marking_pausable_fifo: done, errors");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_ARRIVE;
    pkt_id_i    = '0;
    pkt_size_i  = '0;
    ce_in_i     = 1'b0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_acc      = 1'b0;
    stuck_cycles = 0;
    mismatch_count = 0;
    q_head = 0;
    q_tail = 0;
    q_count = 0;
    q_bytes = '0;
    snd_state = SS_READY;
    drop_total = '0;
    cap_bytes = MAX_BYTES_RST;
    mark_thr = MARK_THR_RST;
    n_accepted = 0;
    n_byte_drops = 0;
    n_full_drops = 0;
    n_departed = 0;
    n_marked = 0;
    n_empty_done = 0;
    n_controls = 0;
    peak_depth = 0;
    send_idle_pct = 14;
    recv_idle_pct = 57;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk under the reset configuration.
    add_item(OP_COMPLETE, 16'h1234, 14'd0, 1'b0);     // completion on empty queue
    add_item(OP_PAUSE, 16'h0001, 14'd0, 1'b0);        // pause with nothing queued
    add_item(OP_ARRIVE, 16'h0000, 14'd0, 1'b0);       // zero-length while paused
    add_item(OP_PAUSE, 16'h0002, 14'd0, 1'b0);        // zero-length counts as in flight
    add_item(OP_COMPLETE, 16'h0003, 14'd0, 1'b0);
    add_item(OP_RESUME, 16'h0004, 14'd0, 1'b0);       // resume with empty queue
    add_item(OP_ARRIVE, 16'hFFFF, 14'h3FFF, 1'b1);    // starts service
    add_item(OP_ARRIVE, 16'h0001, 14'h3FFF, 1'b0);
    add_item(OP_ARRIVE, 16'h0002, 14'h3FFF, 1'b0);
    add_item(OP_ARRIVE, 16'h0003, 14'h3FFF, 1'b0);
    add_item(OP_ARRIVE, 16'h0004, 14'd5, 1'b1);       // one byte over capacity
    add_item(OP_ARRIVE, 16'h0005, 14'd4, 1'b0);       // exactly at capacity
    add_item(OP_ARRIVE, 16'h0006, 14'd0, 1'b1);
    add_item(OP_PAUSE, 16'h0007, 14'h3FFF, 1'b1);
    add_item(OP_COMPLETE, 16'h0008, 14'd0, 1'b0);     // pause received becomes paused
    add_item(OP_RESUME, 16'h0009, 14'd0, 1'b0);       // resume with packets waiting
    repeat (6) add_item(OP_COMPLETE, 16'hA5A5, 14'h2AAA, 1'b1);
    add_item(OP_COMPLETE, 16'h5A5A, 14'h1555, 1'b0);
    add_item(OP_RESUME, 16'h000A, 14'd0, 1'b0);
    drain_queue();

    // Random phases, each under its own configuration; pairs of phases share an idle profile.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      int arrive_pct;
      arrive_pct = 50;
      if (ph < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 57;
      end else if (ph < 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_register(REG_MAX_BYTES, phase_cap[ph]);
      set_register(REG_MARK_THR, phase_thr[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Bursts that fill, hold or empty the queue.
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(0, 2))
            0: arrive_pct = 20;
            1: arrive_pct = 50;
            default: arrive_pct = 85;
          endcase
        end
        pending_items.push_back(rand_item(arrive_pct, phase_sizes[ph]));
      end
      drain_queue();
    end

    $display("Covered %0d accepted, %0d byte-limit drops, %0d store-full drops, %0d controls.",
             n_accepted, n_byte_drops, n_full_drops, n_controls);
    $display("Departures %0d (%0d marked), %0d empty completions, deepest queue %0d.",
             n_departed, n_marked, n_empty_done, peak_depth);
    if (mismatch_count == 0) begin
      $display("tb_ecn_marking_pausable_fifo: done, clean");
    end else begin
      $display("tb_ecn_marking_pausable_fifo: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: ecn_marking_pausable_fifo.f
hdl/ecnq_pkg.sv
hdl/ecnq_desc_ram.sv
hdl/ecnq_cfg.sv
hdl/ecn_marking_pausable_fifo.sv
hdl/ecnq_checker.sv
test/tb_ecn_marking_pausable_fifo.sv
